// ===== rtl/rc4_pkg.sv =====
// shared constants and types for the rc4 stream cipher
`default_nettype none

package rc4_pkg;

    // permutation store geometry
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = $clog2(PERM_DEPTH);
    localparam int BYTE_W     = 8;

    // configuration registers
    localparam int KEY_W         = 64;
    localparam int KEY_BYTES_MAX = KEY_W / BYTE_W;
    localparam int KIDX_W        = $clog2(KEY_BYTES_MAX);
    localparam int KLEN_W        = 4;
    localparam int CFG_IDX_W     = 2;

    localparam logic [KLEN_W-1:0]    KEY_LEN_RESET = KLEN_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_KEY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = CFG_IDX_W'(1);

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

`default_nettype wire

// ===== rtl/rc4_ram.sv =====
// generic single-port ram with registered read
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // one access per cycle, read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ===== rtl/rc4_stream_cipher.sv =====
// rc4 stream cipher top level: sequencer, index registers and permutation store
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one data byte with a
//   start-of-message and a last-of-message flag. Output channel
//   (o_out_valid / i_out_stall) returns the byte xored with the keystream
//   byte and a copy of the last flag. One result per input transfer.
//   The key and key length must be written through the plain write port
//   only while the block is idle; the block itself does not enforce this.
//   They are used at the next start-of-message. A byte without the start
//   flag makes two reads, two swap writes and the keystream read on the
//   single port of the permutation ram, then its result is loaded into the
//   output register; the input stays stalled until then. A byte with the
//   start flag first runs the key schedule, two reads and two swap writes
//   per entry over all 256 entries. The identity fill is done at once by
//   clearing per-entry valid bits, so no clearing pass is needed.
//   Reset (synchronous) restores identity permutation, zero indices, a
//   zero key of length 5, and an empty output register.
//   A stalled result stays in the output register; the next byte is
//   processed up to its keystream read and then waits for the register.
`default_nettype none

module rc4_stream_cipher (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [rc4_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rc4_pkg::KEY_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [rc4_pkg::BYTE_W-1:0]    i_data_byte,
    input  wire logic                          i_start_of_message,
    input  wire logic                          i_last_of_message,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [rc4_pkg::BYTE_W-1:0]    o_result_byte,
    output logic                               o_result_last
);

    import rc4_pkg::*;

    // sequencer codes
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_K_RD_C  = 4'd1;
    localparam logic [3:0] S_K_RD_A  = 4'd2;
    localparam logic [3:0] S_K_WR_C  = 4'd3;
    localparam logic [3:0] S_K_WR_A  = 4'd4;
    localparam logic [3:0] S_P_RD_I  = 4'd5;
    localparam logic [3:0] S_P_RD_J  = 4'd6;
    localparam logic [3:0] S_P_WR_I  = 4'd7;
    localparam logic [3:0] S_P_WR_J  = 4'd8;
    localparam logic [3:0] S_P_RD_K  = 4'd9;
    localparam logic [3:0] S_P_DONE  = 4'd10;

    localparam logic [PERM_AW-1:0] LAST_ENTRY = PERM_AW'(PERM_DEPTH - 1);

    logic [3:0]            r_state, n_state;
    logic [KEY_W-1:0]      r_key;
    logic [KLEN_W-1:0]     r_klen;
    logic [PERM_AW-1:0]    r_c, n_c;
    logic [KIDX_W-1:0]     r_k, n_k;
    t_byte                 r_acc, n_acc;
    t_byte                 r_i, n_i;
    t_byte                 r_j, n_j;
    t_byte                 r_t1, n_t1;
    t_byte                 r_t2, n_t2;
    t_byte                 r_data;
    logic                  r_last;
    logic                  r_rd_vld;
    logic [PERM_AW-1:0]    r_rd_addr;
    logic [PERM_DEPTH-1:0] r_perm_vld;
    logic                  r_out_vld;
    t_byte                 r_out_byte;
    logic                  r_out_last;

    logic                  ram_we, ram_re;
    logic [PERM_AW-1:0]    ram_addr;
    t_byte                 ram_wdata, ram_q;

    logic                  in_xfer, out_xfer, out_load, perm_clear;
    t_byte                 s_rd, key_byte;
    logic [KLEN_W-1:0]     eff_len;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_vld && !i_out_stall;
    assign out_load = (r_state == S_P_DONE) && (!r_out_vld || !i_out_stall);

    // entries never written since the last identity fill read as their index
    assign s_rd = r_rd_vld ? ram_q : t_byte'(r_rd_addr);

    // key byte select and effective key length (saturated to 1..8)
    assign key_byte = r_key[{r_k, 3'b000} +: BYTE_W];

    always_comb begin
        if (r_klen == '0) begin
            eff_len = KLEN_W'(1);
        end else if (r_klen > KLEN_W'(KEY_BYTES_MAX)) begin
            eff_len = KLEN_W'(KEY_BYTES_MAX);
        end else begin
            eff_len = r_klen;
        end
    end

    // sequencer and datapath next values
    always_comb begin
        n_state    = r_state;
        n_c        = r_c;
        n_k        = r_k;
        n_acc      = r_acc;
        n_i        = r_i;
        n_j        = r_j;
        n_t1       = r_t1;
        n_t2       = r_t2;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = r_c;
        ram_wdata  = s_rd;
        perm_clear = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_start_of_message) begin
                        perm_clear = 1'b1;
                        n_c        = '0;
                        n_k        = '0;
                        n_acc      = '0;
                        n_state    = S_K_RD_C;
                    end else begin
                        n_state = S_P_RD_I;
                    end
                end
            end
            S_K_RD_C: begin
                ram_re   = 1'b1;
                ram_addr = r_c;
                n_state  = S_K_RD_A;
            end
            S_K_RD_A: begin
                n_t1     = s_rd;
                n_acc    = r_acc + key_byte + s_rd;
                ram_re   = 1'b1;
                ram_addr = n_acc;
                n_state  = S_K_WR_C;
            end
            S_K_WR_C: begin
                ram_we    = 1'b1;
                ram_addr  = r_c;
                ram_wdata = s_rd;
                n_state   = S_K_WR_A;
            end
            S_K_WR_A: begin
                ram_we    = 1'b1;
                ram_addr  = r_acc;
                ram_wdata = r_t1;
                n_c       = r_c + PERM_AW'(1);
                if (({1'b0, r_k} + KLEN_W'(1)) == eff_len) begin
                    n_k = '0;
                end else begin
                    n_k = r_k + KIDX_W'(1);
                end
                if (r_c == LAST_ENTRY) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = S_P_RD_I;
                end else begin
                    n_state = S_K_RD_C;
                end
            end
            S_P_RD_I: begin
                n_i      = r_i + BYTE_W'(1);
                ram_re   = 1'b1;
                ram_addr = n_i;
                n_state  = S_P_RD_J;
            end
            S_P_RD_J: begin
                n_t1     = s_rd;
                n_j      = r_j + s_rd;
                ram_re   = 1'b1;
                ram_addr = n_j;
                n_state  = S_P_WR_I;
            end
            S_P_WR_I: begin
                n_t2      = s_rd;
                ram_we    = 1'b1;
                ram_addr  = r_i;
                ram_wdata = s_rd;
                n_state   = S_P_WR_J;
            end
            S_P_WR_J: begin
                ram_we    = 1'b1;
                ram_addr  = r_j;
                ram_wdata = r_t1;
                n_state   = S_P_RD_K;
            end
            S_P_RD_K: begin
                ram_re   = 1'b1;
                ram_addr = r_t1 + r_t2;
                n_state  = S_P_DONE;
            end
            S_P_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_key      <= '0;
            r_klen     <= KEY_LEN_RESET;
            r_i        <= '0;
            r_j        <= '0;
            r_perm_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            // configuration writes, unknown indexes ignored
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CIPHER_KEY: r_key  <= i_cfg_data;
                    CFG_KEY_LENGTH: r_klen <= i_cfg_data[KLEN_W-1:0];
                    default: ;
                endcase
            end
            // valid bits: cleared for identity fill, set by each write
            if (perm_clear) begin
                r_perm_vld <= '0;
            end else if (ram_we) begin
                r_perm_vld[ram_addr] <= 1'b1;
            end
            // output register
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (out_xfer) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_c   <= n_c;
        r_k   <= n_k;
        r_acc <= n_acc;
        r_t1  <= n_t1;
        r_t2  <= n_t2;
        if (in_xfer) begin
            r_data <= i_data_byte;
            r_last <= i_last_of_message;
        end
        if (ram_re && !ram_we) begin
            r_rd_vld  <= r_perm_vld[ram_addr];
            r_rd_addr <= ram_addr;
        end
        if (out_load) begin
            r_out_byte <= r_data ^ s_rd;
            r_out_last <= r_last;
        end
    end

    // permutation store
    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    assign o_in_stall    = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid   = r_out_vld;
    assign o_result_byte = r_out_byte;
    assign o_result_last = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/rc4_checker.sv =====
// port-level assertions for the rc4 stream cipher, bound to the top level
`default_nettype none

module rc4_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_result_byte,
    input wire logic       o_result_last
);

    // a transfer makes the block busy on the next cycle
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

    // a new result only appears at the end of a busy period
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work");

    // stalled result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result_byte)
            && $stable(o_result_last)))
        else $error("stalled result changed");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_byte (o_result_byte),
    .o_result_last (o_result_last)
);

`default_nettype wire
